// ===== src/assert_macros.svh =====
// Assertion macros for the checker file jois_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, switched off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

// ===== src/jois_pkg.sv =====
`default_nettype none

package jois_pkg;

	localparam int TIME_W = 16;
	localparam int FINE_W = 16;
	localparam int NUM_W  = 7;

	// One stored job as held in the order memory.
	typedef struct packed {
		logic [TIME_W-1:0] job_time;
		logic [FINE_W-1:0] job_fine;
		logic [NUM_W-1:0]  job_number;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_SHIFT,
		ST_PUT,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

// ===== src/jois_ram.sv =====
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read data.
module jois_ram #(
	parameter int WIDTH = 39,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== src/job_order_insertion_scheduler_unit.sv =====
// With n > 0 jobs stored and insertion point p, a job is written into the order after a scan
// of positions 0 to n, a drain step, a shift of the n - p entries behind p and a put, or
// directly on an empty set; busy drops at that edge. A new job is taken only while idle, and
// the scan and the shift share the single read port of the order memory. A final job then holds
// busy while it streams one result per stored job, one per cycle; the receiver cannot stall.
// Reset: asynchronous, active low; it empties the stored set, and no clearing pass runs.
`default_nettype none

module job_order_insertion_scheduler_unit #(
	parameter int MAX_JOBS = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output logic                              busy,
	input  wire logic [jois_pkg::TIME_W-1:0]  job_time,
	input  wire logic [jois_pkg::FINE_W-1:0]  job_fine,
	input  wire logic                         final_job,
	output logic                              valid,
	output logic      [jois_pkg::NUM_W-1:0]   job_number,
	output logic                              end_of_order
);

	// Address width of the order memory, width of counts that must reach MAX_JOBS,
	// width of a running sum over the whole set, of one product and of one cost.
	localparam int AW   = $clog2(MAX_JOBS);
	localparam int CW   = $clog2(MAX_JOBS + 1);
	localparam int SW   = jois_pkg::TIME_W + CW;
	localparam int PW   = jois_pkg::TIME_W + SW;
	localparam int CSTW = PW + 1;

	jois_pkg::state_t state_q, state_nxt;

	// The arriving job, held for the whole insertion.
	logic [jois_pkg::TIME_W-1:0] t_q;
	logic [jois_pkg::FINE_W-1:0] f_q;
	logic                        fin_q;
	logic [CW-1:0]               n_q;

	// Stored set bookkeeping. The sum of all stored fines is kept in a register so
	// that the cost scan can start at position zero without a separate summing pass.
	logic [CW-1:0] cnt_q;
	logic [SW-1:0] tot_q;

	// Cost scan: before_q is the sum of durations ahead of position k_q, after_q the
	// sum of fines from k_q on. Products are registered, then added and compared.
	logic [SW-1:0]   before_q, after_q;
	logic [CW-1:0]   k_q;
	logic [PW-1:0]   pf_s1, pt_s1;
	logic [CW-1:0]   pos_s1;
	logic            v_s1;
	logic [CSTW-1:0] best_q;
	logic [CW-1:0]   best_pos_q;
	logic [CSTW-1:0] cost;

	// Shift pass: i_q is the destination entry; its predecessor is read, then written.
	logic [CW-1:0] i_q;
	logic          shf_v_s1;
	logic [AW-1:0] shf_addr_s1;

	// Emission.
	logic [CW-1:0] e_q;
	logic [CW-1:0] emn_q;
	logic          valid_q, end_q;

	// Memory ports.
	logic             rd_en, wr_en;
	logic [AW-1:0]    rd_addr, wr_addr;
	jois_pkg::entry_t rd_data, wr_data;

	logic          accept;
	logic          full;
	logic [CW-1:0] k_inc, i_dec, n_inc;
	logic          shf_rd;
	logic          emit_last;

	assign accept    = start && (state_q == jois_pkg::ST_IDLE);
	assign full      = (cnt_q == CW'(MAX_JOBS));
	assign k_inc     = k_q + CW'(1);
	assign i_dec     = i_q - CW'(1);
	assign n_inc     = n_q + CW'(1);
	assign shf_rd    = (i_q > best_pos_q);
	assign emit_last = (e_q == emn_q - CW'(1));
	assign cost      = CSTW'(pf_s1) + CSTW'(pt_s1);

	jois_ram #(
		.WIDTH($bits(jois_pkg::entry_t)),
		.DEPTH(MAX_JOBS)
	) u_order_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			jois_pkg::ST_IDLE: begin
				if (accept) begin
					if (full) begin
						// A job that finds the set full is dropped; a final one still
						// releases the stored order.
						state_nxt = final_job ? jois_pkg::ST_EMIT : jois_pkg::ST_IDLE;
					end else if (cnt_q == '0) begin
						state_nxt = jois_pkg::ST_PUT;
					end else begin
						state_nxt = jois_pkg::ST_SCAN;
					end
				end
			end
			jois_pkg::ST_SCAN: begin
				if (k_q == n_q) begin
					state_nxt = jois_pkg::ST_DRAIN;
				end
			end
			jois_pkg::ST_DRAIN: begin
				state_nxt = jois_pkg::ST_SHIFT;
			end
			jois_pkg::ST_SHIFT: begin
				if (!shf_rd) begin
					state_nxt = jois_pkg::ST_PUT;
				end
			end
			jois_pkg::ST_PUT: begin
				state_nxt = fin_q ? jois_pkg::ST_EMIT : jois_pkg::ST_IDLE;
			end
			jois_pkg::ST_EMIT: begin
				if (emit_last) begin
					state_nxt = jois_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = jois_pkg::ST_IDLE;
			end
		endcase
	end

	// Memory port control. Read data is used in the cycle after its read: during
	// the scan it advances the running sums, during the shift it is written one entry
	// further down, and during emission it drives job_number directly.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		unique case (state_q)
			jois_pkg::ST_IDLE: begin
				rd_en = accept;
			end
			jois_pkg::ST_SCAN: begin
				rd_en   = (k_inc < n_q);
				rd_addr = k_inc[AW-1:0];
			end
			jois_pkg::ST_SHIFT: begin
				rd_en   = shf_rd;
				rd_addr = i_dec[AW-1:0];
			end
			jois_pkg::ST_EMIT: begin
				rd_en   = 1'b1;
				rd_addr = e_q[AW-1:0];
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// The last shift write always lands in the final shift cycle, so it never meets
	// the write of the new job in the following cycle.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = shf_addr_s1;
		wr_data = rd_data;
		if (shf_v_s1) begin
			wr_en = 1'b1;
		end else if (state_q == jois_pkg::ST_PUT) begin
			wr_en              = 1'b1;
			wr_addr            = best_pos_q[AW-1:0];
			wr_data.job_time   = t_q;
			wr_data.job_fine   = f_q;
			wr_data.job_number = jois_pkg::NUM_W'(n_inc);
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= jois_pkg::ST_IDLE;
			cnt_q    <= '0;
			tot_q    <= '0;
			v_s1     <= 1'b0;
			shf_v_s1 <= 1'b0;
			valid_q  <= 1'b0;
			end_q    <= 1'b0;
			k_q      <= '0;
			i_q      <= '0;
			e_q      <= '0;
			emn_q    <= '0;
		end else begin
			state_q  <= state_nxt;
			v_s1     <= (state_q == jois_pkg::ST_SCAN);
			shf_v_s1 <= (state_q == jois_pkg::ST_SHIFT) && shf_rd;
			valid_q  <= (state_q == jois_pkg::ST_EMIT);
			end_q    <= (state_q == jois_pkg::ST_EMIT) && emit_last;
			unique case (state_q)
				jois_pkg::ST_IDLE: begin
					if (accept) begin
						k_q   <= '0;
						e_q   <= '0;
						emn_q <= cnt_q;
						if (full && final_job) begin
							cnt_q <= '0;
							tot_q <= '0;
						end
					end
				end
				jois_pkg::ST_SCAN: begin
					k_q <= k_inc;
				end
				jois_pkg::ST_DRAIN: begin
					i_q <= n_q;
				end
				jois_pkg::ST_SHIFT: begin
					if (shf_rd) begin
						i_q <= i_dec;
					end
				end
				jois_pkg::ST_PUT: begin
					emn_q <= n_inc;
					e_q   <= '0;
					if (fin_q) begin
						cnt_q <= '0;
						tot_q <= '0;
					end else begin
						cnt_q <= n_inc;
						tot_q <= tot_q + SW'(f_q);
					end
				end
				jois_pkg::ST_EMIT: begin
					e_q <= e_q + CW'(1);
				end
				default: begin
					k_q <= k_q;
				end
			endcase
		end
	end

	// Job payload and scan datapath.
	always_ff @(posedge clk) begin
		if (accept) begin
			t_q        <= job_time;
			f_q        <= job_fine;
			fin_q      <= final_job;
			n_q        <= cnt_q;
			before_q   <= '0;
			after_q    <= tot_q;
			best_pos_q <= '0;
		end
		if (state_q == jois_pkg::ST_SCAN) begin
			pf_s1  <= f_q * before_q;
			pt_s1  <= t_q * after_q;
			pos_s1 <= k_q;
			if (k_q < n_q) begin
				before_q <= before_q + SW'(rd_data.job_time);
				after_q  <= after_q - SW'(rd_data.job_fine);
			end
		end
		// Least cost wins; an equal cost at a later position also wins.
		if (v_s1 && ((pos_s1 == '0) || (cost <= best_q))) begin
			best_q     <= cost;
			best_pos_q <= pos_s1;
		end
		if (state_q == jois_pkg::ST_SHIFT) begin
			shf_addr_s1 <= i_q[AW-1:0];
		end
	end

	assign busy         = (state_q != jois_pkg::ST_IDLE);
	assign valid        = valid_q;
	assign end_of_order = end_q;
	assign job_number   = rd_data.job_number;

endmodule

`default_nettype wire

// ===== src/jois_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module jois_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        start,
	input wire logic                        busy,
	input wire logic                        final_job,
	input wire logic                        valid,
	input wire logic [jois_pkg::NUM_W-1:0]  job_number,
	input wire logic                        end_of_order
);

	logic accepted;
	assign accepted = start && !busy;

	`ASSERT_IMPLIES(a_end_marks_result, clk, arst_n, end_of_order, valid)
	`ASSERT_IMPLIES(a_number_nonzero, clk, arst_n, valid, job_number != '0)
	`ASSERT_NEXT(a_result_follows_busy, clk, arst_n, !busy && !valid, !valid)
	`ASSERT_NEXT(a_order_ends_cleanly, clk, arst_n, end_of_order, !valid)
	`ASSERT_NEXT(a_plain_job_silent, clk, arst_n, accepted && !final_job, !valid)

endmodule

bind job_order_insertion_scheduler_unit jois_checker u_jois_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.final_job   (final_job),
	.valid       (valid),
	.job_number  (job_number),
	.end_of_order(end_of_order)
);

`default_nettype wire

// ===== dv/job_order_checker.sv =====
`default_nettype none

module job_order_checker #(
	parameter int MAX_JOBS = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic                         busy,
	input  wire logic [jois_pkg::TIME_W-1:0]  job_time,
	input  wire logic [jois_pkg::FINE_W-1:0]  job_fine,
	input  wire logic                         final_job,
	input  wire logic                         valid,
	input  wire logic [jois_pkg::NUM_W-1:0]   job_number,
	input  wire logic                         end_of_order,
	output int unsigned                       pending,
	output int unsigned                       mismatches,
	output int unsigned                       results_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import jois_pkg::*;

	typedef struct packed {
		logic [NUM_W-1:0] number;
		logic             is_end;
	} order_slot_t;

	order_slot_t       order_queue[$];
	logic [TIME_W-1:0] held_time[MAX_JOBS];
	logic [FINE_W-1:0] held_fine[MAX_JOBS];
	logic [NUM_W-1:0]  held_number[MAX_JOBS];
	int unsigned       held_count = 0;
	int unsigned       bad_count = 0;
	int unsigned       seen_count = 0;

	// Cheapest insertion point by Smith's rule; ties go to the later position.
	function automatic int unsigned cheapest_slot(logic [TIME_W-1:0] t, logic [FINE_W-1:0] f);
		logic [63:0] dur_before;
		logic [63:0] fine_after;
		logic [63:0] cost;
		logic [63:0] best;
		int unsigned best_k;
		dur_before = '0;
		fine_after = '0;
		best = '0;
		best_k = 0;
		for (int unsigned k = 0; k < held_count; k++)
			fine_after += 64'(held_fine[k]);
		for (int unsigned k = 0; k <= held_count; k++) begin
			cost = 64'(f) * dur_before + 64'(t) * fine_after;
			if (k == 0 || cost <= best) begin
				best = cost;
				best_k = k;
			end
			if (k < held_count) begin
				dur_before += 64'(held_time[k]);
				fine_after -= 64'(held_fine[k]);
			end
		end
		return best_k;
	endfunction

	task automatic insert_job(logic [TIME_W-1:0] t, logic [FINE_W-1:0] f, logic is_final);
		int unsigned slot;
		if (held_count < MAX_JOBS) begin
			slot = cheapest_slot(t, f);
			for (int unsigned i = held_count; i > slot; i--) begin
				held_time[i] = held_time[i-1];
				held_fine[i] = held_fine[i-1];
				held_number[i] = held_number[i-1];
			end
			held_time[slot] = t;
			held_fine[slot] = f;
			held_number[slot] = NUM_W'(held_count + 1);
			held_count++;
		end
		if (is_final) begin
			for (int unsigned i = 0; i < held_count; i++)
				order_queue.push_back('{number: held_number[i], is_end: (i + 1 == held_count)});
			held_count = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		order_slot_t want;
		if (!arst_n) begin
			order_queue.delete();
			held_count = 0;
		end else begin
			if (valid) begin
				seen_count++;
				if (order_queue.size() == 0) begin
					bad_count++;
					$error("job_number: unexpected result, expected none, actual %0d", job_number);
				end else begin
					want = order_queue.pop_front();
					if (job_number !== want.number) begin
						bad_count++;
						$error("job_number: expected %0d, actual %0d", want.number, job_number);
					end
					if (end_of_order !== want.is_end) begin
						bad_count++;
						$error("end_of_order: expected %0d, actual %0d", want.is_end,
							end_of_order);
					end
				end
			end
			if (start && !busy)
				insert_job(job_time, job_fine, final_job);
		end
		pending <= order_queue.size();
		mismatches <= bad_count;
		results_checked <= seen_count;
	end

endmodule

`default_nettype wire

// ===== dv/tb_job_order_insertion_scheduler_unit.sv =====
`default_nettype none

// Stimulus and verdict for the job order scheduler. The checker beside the block watches
// every transfer, keeps its own ordered job list and compares each emitted job number.
module tb_job_order_insertion_scheduler_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import jois_pkg::*;

	localparam int CAPACITY     = 64;
	localparam int RANDOM_JOBS  = 400;
	// Worst case per job is a scan and a shift over the stored set, plus a gap and a
	// full order stream; the limit is several times that over all jobs.
	localparam int CYCLE_LIMIT  = 600_000;
	// After the last expected result, wait long enough for one more scan, shift and
	// stream of a full set so that a stray result would still be caught.
	localparam int TAIL_CYCLES  = 3 * CAPACITY + 16;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [TIME_W-1:0] job_time = '0;
	logic [FINE_W-1:0] job_fine = '0;
	logic              final_job = 1'b0;
	logic              busy;
	logic              valid;
	logic [NUM_W-1:0]  job_number;
	logic              end_of_order;

	int unsigned pending;
	int unsigned mismatches;
	int unsigned results_checked;

	int unsigned cycle_count = 0;
	int unsigned jobs_sent = 0;
	int unsigned sets_sent = 0;
	int unsigned overflow_sets = 0;
	int unsigned burst_left = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	job_order_insertion_scheduler_unit #(
		.MAX_JOBS(CAPACITY)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.job_time(job_time),
		.job_fine(job_fine),
		.final_job(final_job),
		.valid(valid),
		.job_number(job_number),
		.end_of_order(end_of_order)
	);

	job_order_checker #(
		.MAX_JOBS(CAPACITY)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.job_time(job_time),
		.job_fine(job_fine),
		.final_job(final_job),
		.valid(valid),
		.job_number(job_number),
		.end_of_order(end_of_order),
		.pending(pending),
		.mismatches(mismatches),
		.results_checked(results_checked)
	);

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$error("timeout after %0d cycles with %0d results outstanding", cycle_count,
				pending);
			$display("FAIL");
			$finish;
		end
	end

	// Field values lean toward the extremes and toward tiny values, which make equal
	// costs common; the rest are full-width random so every bit toggles.
	function automatic logic [TIME_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return TIME_W'($urandom_range(0, 7));
			4: return TIME_W'($urandom_range(65528, 65535));
			default: return TIME_W'($urandom);
		endcase
	endfunction

	// Holds start high with the job until the block takes it. The task returns in the
	// time step of the transfer and leaves start high, so that a following job can go
	// out back to back without start being lowered and raised in the same step.
	task automatic send_job(logic [TIME_W-1:0] t, logic [FINE_W-1:0] f, logic is_final);
		start <= 1'b1;
		job_time <= t;
		job_fine <= f;
		final_job <= is_final;
		do @(posedge clk); while (busy);
		jobs_sent++;
	endtask

	// Drops start for a number of cycles; the fields carry noise meanwhile, which the
	// block must ignore.
	task automatic idle(int unsigned cycles);
		start <= 1'b0;
		job_time <= TIME_W'($urandom);
		job_fine <= FINE_W'($urandom);
		final_job <= 1'($urandom);
		repeat (cycles) @(posedge clk);
	endtask

	// Bursts of back-to-back transfers separated by random gaps. Since job processing
	// time grows with the set size, the gaps land in every phase of the scan, the
	// shift and the order stream.
	task automatic pace();
		if (burst_left != 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			idle($urandom_range(1, 16));
		end
	endtask

	// Stops sending until every expected job number has come out of the block.
	task automatic drain();
		idle(1);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		int unsigned set_size;
		int unsigned set_idx;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed sets. A lone final job on an empty set gives a one-entry order.
		send_job('0, '0, 1'b1);
		pace();
		// All-zero costs: each new job lands at the end, so arrival order stays.
		send_job('0, '0, 1'b0);
		send_job('0, '0, 1'b0);
		send_job('0, '0, 1'b1);
		pace();
		// Largest durations and fines.
		send_job('1, '1, 1'b0);
		send_job('1, 16'd1, 1'b0);
		send_job(16'd1, '1, 1'b1);
		pace();
		// Equal ratios give equal costs everywhere; the later position must win.
		send_job(16'd2, 16'd2, 1'b0);
		send_job(16'd1, 16'd1, 1'b0);
		send_job(16'd3, 16'd3, 1'b1);
		pace();
		// Zero fine or zero duration on one side of the comparison.
		send_job(16'd5, '0, 1'b0);
		send_job('0, 16'd5, 1'b0);
		send_job(16'd3, '0, 1'b1);
		pace();
		// A mix that Smith's rule reorders.
		send_job(16'd1, 16'd10, 1'b0);
		send_job(16'd10, 16'd1, 1'b0);
		send_job(16'd5, 16'd5, 1'b0);
		send_job('1, '0, 1'b0);
		send_job('0, '1, 1'b1);
		drain();
		sets_sent = 6;

		// Random sets, mostly small. One set fills the list exactly with its final job,
		// and one overflows it so that jobs, the final one included, are dropped.
		set_idx = 0;
		while (jobs_sent < 18 + RANDOM_JOBS) begin
			if (set_idx == 4)
				set_size = CAPACITY;
			else if (set_idx == 9)
				set_size = CAPACITY + 3;
			else if ($urandom_range(0, 11) == 0)
				set_size = $urandom_range(16, 40);
			else
				set_size = $urandom_range(1, 10);
			if (set_size > CAPACITY)
				overflow_sets++;
			for (int unsigned j = 0; j < set_size; j++) begin
				send_job(pick_value(), pick_value(), j + 1 == set_size);
				if (j + 1 == set_size && (set_idx == 2 || $urandom_range(0, 7) == 0))
					drain();
				else
					pace();
			end
			set_idx++;
			sets_sent++;
		end

		// Wind down: let the last order stream out, then watch for stray results.
		idle(1);
		while (pending != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run covered %0d jobs in %0d sets, %0d of them past capacity.",
			jobs_sent, sets_sent, overflow_sets);
		$display("Checked %0d emitted job numbers against the predicted order.",
			results_checked);
		if (mismatches == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

`default_nettype wire
